// ===== sv/grid_ray_cast_distance_macros.svh =====
// ----------------------------------------------------------------------------
// Grid ray cast distance assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CAST_DISTANCE_MACROS_SVH
`define GRID_RAY_CAST_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define GRCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grcd assertion failed");
// next-cycle implication
`define GRCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grcd assertion failed");
`else
`define GRCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GRCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/grcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid ray cast distance package
// Shared constants, widths and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package grcd_pkg;

    // parameter defaults
    localparam int MAP_TILES_DEF  = 8;
    localparam int MAX_STEPS_DEF  = 8;
    localparam int TILE_SHIFT_DEF = 6;

    // datapath widths, sized for the largest tile shift
    localparam int MUL_W  = 21;
    localparam int MUL_PW = 2 * MUL_W;
    localparam int DIV_NW = 30;
    localparam int DIV_DW = 15;
    localparam int SQ_IW  = 38;
    localparam int SQ_RW  = SQ_IW / 2;
    localparam int POS_W  = 40;
    localparam int TRIG_W = 16;
    localparam int HIT_W  = 19;
    localparam int OUT_W  = 21;

    localparam logic [OUT_W-1:0] FAR_MARK = OUT_W'(1280000);

    // sine polynomial coefficients
    localparam logic [10:0] SIN_C3 = 11'd1142;
    localparam logic [13:0] SIN_C2 = 14'd10477;
    localparam logic [14:0] SIN_C1 = 15'd25719;

    typedef enum logic [1:0] {
        CFG_MAP_CELLS,
        CFG_MAP_DIM,
        CFG_FOV,
        CFG_RAYS
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TRIG_SIN,
        TRIG_COS,
        TRIG_FISH
    } trig_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG_MUL,
        ST_ANG_DIV,
        ST_ANG_WAIT,
        ST_SIN_Z2,
        ST_SIN_M1,
        ST_SIN_M2,
        ST_SIN_S,
        ST_SIN_END,
        ST_DIR,
        ST_SET_MUL,
        ST_SET_DIV,
        ST_SET_WAIT,
        ST_WALK,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_SQ_WAIT,
        ST_NEXT,
        ST_PICK,
        ST_COR_MUL,
        ST_COR_END
    } state_t;

endpackage

`default_nettype wire

// ===== sv/grcd_div.sv =====
// ----------------------------------------------------------------------------
// Grid ray cast iterative divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grcd_div
    import grcd_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);

    localparam int CW = $clog2(NW + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   rem_sh;
    logic          fits;

    // shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== sv/grcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Grid ray cast iterative square root
// Floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grcd_sqrt
    import grcd_pkg::*;
#(
    parameter int IW = SQ_IW
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            go,
    input  wire logic [IW-1:0]   rad,
    output logic                 done,
    output logic [IW/2-1:0]      root
);

    localparam int RW = IW / 2;
    localparam int CW = $clog2(RW + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW:0]   rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [IW-1:0] rad_reg, rad_next;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          fits;

    // bring down two radicand bits and test root*4+1
    assign rem_sh = {rem_reg, rad_reg[IW-1:IW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rad_next  = rad_reg;
        if (go)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            root_next = '0;
            rad_next  = rad;
        end
        else if (run_reg)
        begin
            rad_next  = {rad_reg[IW-3:0], 2'b00};
            rem_next  = fits ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
            root_next = {root_reg[RW-2:0], fits};
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(RW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== sv/grid_ray_cast_distance.sv =====
// ----------------------------------------------------------------------------
// Grid ray cast distance
// Casts one ray through a tile map and returns the corrected wall distance.
// ----------------------------------------------------------------------------
// Usage: load the map and view setup on the cfg_we/cfg_index/cfg_data port
// while the block is idle. Raise start with start_x, start_y, view_angle and
// ray_index; the transaction is taken when start is high and busy is low.
// busy stays high while the ray is worked on; one cycle of done then carries
// corrected_distance, hit_x, hit_y, wall_side and wall_found. The receiver
// cannot stall: the result is shown for that single cycle only.
// Rays are worked on one at a time. The time per ray is set by the shared
// divider (ray angle, then two crossing offsets per walk), the square root
// per hit, up to MAX_STEPS tested crossings per walk and the shared
// multiplier that also evaluates three sines.
// Reset returns to idle and loads the default map size, field of view and ray
// count with an empty map.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_ray_cast_distance_macros.svh"

module grid_ray_cast_distance
    import grcd_pkg::*;
#(
    parameter int MAP_TILES  = MAP_TILES_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int TILE_SHIFT = TILE_SHIFT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] start_x,
    input  wire logic [15:0] start_y,
    input  wire logic [11:0] view_angle,
    input  wire logic [7:0]  ray_index,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output logic             done,
    output logic [20:0]      corrected_distance,
    output logic [15:0]      hit_x,
    output logic [15:0]      hit_y,
    output logic             wall_side,
    output logic             wall_found
);

    localparam int PS     = TILE_SHIFT + 7;
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam logic signed [POS_W-1:0] TQ = POS_W'(64'd1 << PS);

    // configuration
    logic [63:0] map_cells_reg;
    logic [3:0]  map_dim_reg;
    logic [10:0] fov_reg;
    logic [8:0]  rays_reg;

    // sequencer and datapath registers
    state_t                    state_reg, state_next;
    logic                      done_reg, done_next;
    logic [15:0]               sx_reg, sx_next;
    logic [15:0]               sy_reg, sy_next;
    logic [11:0]               view_reg, view_next;
    logic [7:0]                idx_reg, idx_next;
    logic [11:0]               ang_reg, ang_next;
    trig_sel_t                 sel_reg, sel_next;
    logic signed [TRIG_W-1:0]  sn_reg, sn_next;
    logic signed [TRIG_W-1:0]  cs_reg, cs_next;
    logic signed [TRIG_W-1:0]  cf_reg, cf_next;
    logic [14:0]               z2_reg, z2_next;
    logic signed [MUL_PW-1:0]  prod_reg;
    logic                      dir_reg, dir_next;
    logic                      pass_reg, pass_next;
    logic                      qneg_reg, qneg_next;
    logic signed [POS_W-1:0]   wp_reg, wp_next;
    logic signed [POS_W-1:0]   wo_reg, wo_next;
    logic signed [POS_W-1:0]   pstep_reg, pstep_next;
    logic signed [POS_W-1:0]   ostep_reg, ostep_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      fh_reg, fh_next;
    logic                      fv_reg, fv_next;
    logic [HIT_W-1:0]          hxh_reg, hxh_next;
    logic [HIT_W-1:0]          hyh_reg, hyh_next;
    logic [HIT_W-1:0]          hxv_reg, hxv_next;
    logic [HIT_W-1:0]          hyv_reg, hyv_next;
    logic [SQ_RW-1:0]          dh_reg, dh_next;
    logic [SQ_RW-1:0]          dv_reg, dv_next;
    logic [SQ_IW-1:0]          sq_reg, sq_next;
    logic [SQ_RW-1:0]          dsel_reg, dsel_next;
    logic [OUT_W-1:0]          corr_reg, corr_next;
    logic [15:0]               ox_reg, ox_next;
    logic [15:0]               oy_reg, oy_next;
    logic                      oside_reg, oside_next;
    logic                      ofound_reg, ofound_next;

    // shared units
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic                      div_go;
    logic [DIV_NW-1:0]         div_num;
    logic [DIV_DW-1:0]         div_den;
    logic                      div_done;
    logic [DIV_NW-1:0]         div_quo;
    logic                      sq_go;
    logic [SQ_IW-1:0]          sq_rad;
    logic                      sq_done;
    logic [SQ_RW-1:0]          sq_root;

    // combinational helpers
    logic                      accept;
    logic [11:0]               trig_arg;
    logic [10:0]               sin_r;
    logic [14:0]               sin_z;
    logic [14:0]               sin_s;
    logic signed [TRIG_W-1:0]  sin_val;
    logic [3:0]                dim;
    logic [15:0]               a16;
    logic [15:0]               base16;
    logic signed [POS_W-1:0]   a_pos;
    logic signed [POS_W-1:0]   o_pos;
    logic signed [TRIG_W-1:0]  den_trig;
    logic signed [TRIG_W-1:0]  num_trig;
    logic signed [POS_W-1:0]   p0;
    logic signed [MUL_PW-1:0]  prod_abs;
    logic signed [TRIG_W-1:0]  den_abs;
    logic signed [POS_W-1:0]   q_pos;
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    logic [POS_W-PS-1:0]       col;
    logic [POS_W-PS-1:0]       row;
    logic                      walk_oob;
    logic                      walk_hit;
    logic                      walk_last;
    logic [HIT_W-1:0]          hx_cur;
    logic [HIT_W-1:0]          hy_cur;
    logic signed [MUL_W-1:0]   ddx;
    logic signed [MUL_W-1:0]   ddy;
    logic [OUT_W-1:0]          dh_far;
    logic [OUT_W-1:0]          dv_far;
    logic                      pick_v;
    logic                      pick_found;
    logic [MUL_PW-1:0]         cor_sum;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = state_reg != ST_IDLE;

    // sine argument and quadrant folding
    always_comb
    begin
        case (sel_reg)
            TRIG_SIN: trig_arg = ang_reg;
            TRIG_COS: trig_arg = ang_reg + 12'd1024;
            default:  trig_arg = view_reg - ang_reg + 12'd1024;
        endcase
    end

    assign sin_r   = trig_arg[10] ? (11'd1024 - {1'b0, trig_arg[9:0]}) : {1'b0, trig_arg[9:0]};
    assign sin_z   = {sin_r, 4'b0000};
    assign sin_s   = prod_reg[28:14];
    assign sin_val = trig_arg[11] ? -$signed({1'b0, sin_s}) : $signed({1'b0, sin_s});

    // walk geometry; direction 0 crosses horizontal lines, 1 vertical lines
    assign dim      = (map_dim_reg > 4'(MAP_TILES)) ? 4'(MAP_TILES) : map_dim_reg;
    assign a16      = dir_reg ? sx_reg : sy_reg;
    assign base16   = (a16 >> PS) << PS;
    assign a_pos    = POS_W'(a16);
    assign o_pos    = POS_W'(dir_reg ? sy_reg : sx_reg);
    assign den_trig = dir_reg ? cs_reg : sn_reg;
    assign num_trig = dir_reg ? sn_reg : cs_reg;
    assign p0       = den_trig[TRIG_W-1] ? (POS_W'(base16) - POS_W'(1))
                                         : (POS_W'(base16) + TQ);
    assign prod_abs = prod_reg[MUL_PW-1] ? -prod_reg : prod_reg;
    assign den_abs  = den_trig[TRIG_W-1] ? -den_trig : den_trig;
    assign q_pos    = qneg_reg ? -POS_W'(div_quo) : POS_W'(div_quo);

    assign px        = dir_reg ? wp_reg : wo_reg;
    assign py        = dir_reg ? wo_reg : wp_reg;
    assign col       = px[POS_W-1:PS];
    assign row       = py[POS_W-1:PS];
    assign walk_oob  = px[POS_W-1] || py[POS_W-1]
                       || (col >= (POS_W-PS)'(dim)) || (row >= (POS_W-PS)'(dim));
    assign walk_hit  = !walk_oob && map_cells_reg[{col[2:0], row[2:0]}];
    assign walk_last = step_reg == STEP_W'(MAX_STEPS - 1);

    assign hx_cur = dir_reg ? hxv_reg : hxh_reg;
    assign hy_cur = dir_reg ? hyv_reg : hyh_reg;
    assign ddx    = $signed(MUL_W'(hx_cur)) - $signed(MUL_W'(sx_reg));
    assign ddy    = $signed(MUL_W'(hy_cur)) - $signed(MUL_W'(sy_reg));

    assign dh_far     = fh_reg ? OUT_W'(dh_reg) : FAR_MARK;
    assign dv_far     = fv_reg ? OUT_W'(dv_reg) : FAR_MARK;
    assign pick_v     = dv_far < dh_far;
    assign pick_found = pick_v ? fv_reg : fh_reg;
    assign cor_sum    = MUL_PW'(prod_reg) + MUL_PW'(8192);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ANG_MUL:
            begin
                mul_a = MUL_W'(idx_reg);
                mul_b = MUL_W'(fov_reg);
            end
            ST_SIN_Z2:
            begin
                mul_a = MUL_W'(sin_z);
                mul_b = MUL_W'(sin_z);
            end
            ST_SIN_M1:
            begin
                mul_a = MUL_W'(prod_reg[28:14]);
                mul_b = MUL_W'(SIN_C3);
            end
            ST_SIN_M2:
            begin
                mul_a = MUL_W'(z2_reg);
                mul_b = MUL_W'(SIN_C2 - 14'(prod_reg[24:14]));
            end
            ST_SIN_S:
            begin
                mul_a = MUL_W'(sin_z);
                mul_b = MUL_W'(SIN_C1 - prod_reg[28:14]);
            end
            ST_SET_MUL:
            begin
                mul_a = pass_reg ? MUL_W'(pstep_reg) : MUL_W'(wp_reg - a_pos);
                mul_b = MUL_W'(num_trig);
            end
            ST_SQ_X:
            begin
                mul_a = ddx;
                mul_b = ddx;
            end
            ST_SQ_Y:
            begin
                mul_a = ddy;
                mul_b = ddy;
            end
            ST_COR_MUL:
            begin
                mul_a = MUL_W'(dsel_reg);
                mul_b = cf_reg[TRIG_W-1] ? '0 : MUL_W'(cf_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider and root operands
    assign div_go  = (state_reg == ST_ANG_DIV) || (state_reg == ST_SET_DIV);
    assign div_num = (state_reg == ST_ANG_DIV) ? DIV_NW'(prod_reg[18:0])
                                               : prod_abs[DIV_NW-1:0];
    assign div_den = (state_reg == ST_ANG_DIV)
                     ? ((rays_reg > 9'd1) ? DIV_DW'(rays_reg - 9'd1) : DIV_DW'(1))
                     : den_abs[DIV_DW-1:0];
    assign sq_go   = state_reg == ST_SQ_SUM;
    assign sq_rad  = sq_reg + prod_reg[SQ_IW-1:0];

    grcd_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    grcd_sqrt #(
        .IW (SQ_IW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sq_go),
        .rad   (sq_rad),
        .done  (sq_done),
        .root  (sq_root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_ANG_MUL;
            ST_ANG_MUL:  state_next = ST_ANG_DIV;
            ST_ANG_DIV:  state_next = ST_ANG_WAIT;
            ST_ANG_WAIT: if (div_done) state_next = ST_SIN_Z2;
            ST_SIN_Z2:   state_next = ST_SIN_M1;
            ST_SIN_M1:   state_next = ST_SIN_M2;
            ST_SIN_M2:   state_next = ST_SIN_S;
            ST_SIN_S:    state_next = ST_SIN_END;
            ST_SIN_END:  state_next = (sel_reg == TRIG_FISH) ? ST_DIR : ST_SIN_Z2;
            ST_DIR:      state_next = (den_trig == '0) ? ST_NEXT : ST_SET_MUL;
            ST_SET_MUL:  state_next = ST_SET_DIV;
            ST_SET_DIV:  state_next = ST_SET_WAIT;
            ST_SET_WAIT:
            begin
                if (div_done) state_next = pass_reg ? ST_WALK : ST_SET_MUL;
            end
            ST_WALK:
            begin
                if (walk_hit) state_next = ST_SQ_X;
                else if (walk_oob || walk_last) state_next = ST_NEXT;
            end
            ST_SQ_X:     state_next = ST_SQ_Y;
            ST_SQ_Y:     state_next = ST_SQ_SUM;
            ST_SQ_SUM:   state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  if (sq_done) state_next = ST_NEXT;
            ST_NEXT:     state_next = dir_reg ? ST_PICK : ST_DIR;
            ST_PICK:     state_next = pick_found ? ST_COR_MUL : ST_IDLE;
            ST_COR_MUL:  state_next = ST_COR_END;
            ST_COR_END:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        done_next   = 1'b0;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        view_next   = view_reg;
        idx_next    = idx_reg;
        ang_next    = ang_reg;
        sel_next    = sel_reg;
        sn_next     = sn_reg;
        cs_next     = cs_reg;
        cf_next     = cf_reg;
        z2_next     = z2_reg;
        dir_next    = dir_reg;
        pass_next   = pass_reg;
        qneg_next   = qneg_reg;
        wp_next     = wp_reg;
        wo_next     = wo_reg;
        pstep_next  = pstep_reg;
        ostep_next  = ostep_reg;
        step_next   = step_reg;
        fh_next     = fh_reg;
        fv_next     = fv_reg;
        hxh_next    = hxh_reg;
        hyh_next    = hyh_reg;
        hxv_next    = hxv_reg;
        hyv_next    = hyv_reg;
        dh_next     = dh_reg;
        dv_next     = dv_reg;
        sq_next     = sq_reg;
        dsel_next   = dsel_reg;
        corr_next   = corr_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oside_next  = oside_reg;
        ofound_next = ofound_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // latch the transaction
                if (accept)
                begin
                    sx_next   = start_x;
                    sy_next   = start_y;
                    view_next = view_angle;
                    idx_next  = ray_index;
                    sel_next  = TRIG_SIN;
                    dir_next  = 1'b0;
                    fh_next   = 1'b0;
                    fv_next   = 1'b0;
                end
            end
            ST_ANG_WAIT:
            begin
                if (div_done)
                    ang_next = view_reg - {2'b00, fov_reg[10:1]} + div_quo[11:0];
            end
            ST_SIN_M1:
            begin
                z2_next = prod_reg[28:14];
            end
            ST_SIN_END:
            begin
                // store the finished sine and advance to the next one, if any
                case (sel_reg)
                    TRIG_SIN:
                    begin
                        sn_next  = sin_val;
                        sel_next = TRIG_COS;
                    end
                    TRIG_COS:
                    begin
                        cs_next  = sin_val;
                        sel_next = TRIG_FISH;
                    end
                    default:
                    begin
                        cf_next  = sin_val;
                    end
                endcase
            end
            ST_DIR:
            begin
                wp_next    = p0;
                pstep_next = den_trig[TRIG_W-1] ? -TQ : TQ;
                pass_next  = 1'b0;
                step_next  = '0;
            end
            ST_SET_DIV:
            begin
                qneg_next = prod_reg[MUL_PW-1] ^ den_trig[TRIG_W-1];
            end
            ST_SET_WAIT:
            begin
                if (div_done)
                begin
                    if (pass_reg)
                        ostep_next = q_pos;
                    else
                    begin
                        wo_next   = o_pos + q_pos;
                        pass_next = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                // test one crossing; on a miss, advance to the next
                if (walk_hit)
                begin
                    if (dir_reg)
                    begin
                        fv_next  = 1'b1;
                        hxv_next = px[HIT_W-1:0];
                        hyv_next = py[HIT_W-1:0];
                    end
                    else
                    begin
                        fh_next  = 1'b1;
                        hxh_next = px[HIT_W-1:0];
                        hyh_next = py[HIT_W-1:0];
                    end
                end
                else
                begin
                    wp_next   = wp_reg + pstep_reg;
                    wo_next   = wo_reg + ostep_reg;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SQ_Y:
            begin
                sq_next = prod_reg[SQ_IW-1:0];
            end
            ST_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    if (dir_reg)
                        dv_next = sq_root;
                    else
                        dh_next = sq_root;
                end
            end
            ST_NEXT:
            begin
                dir_next = 1'b1;
            end
            ST_PICK:
            begin
                // nearer hit wins, a tie goes to the horizontal walk
                oside_next  = !pick_v;
                ofound_next = pick_found;
                dsel_next   = pick_v ? dv_reg : dh_reg;
                if (pick_found)
                begin
                    ox_next = pick_v ? hxv_reg[15:0] : hxh_reg[15:0];
                    oy_next = pick_v ? hyv_reg[15:0] : hyh_reg[15:0];
                end
                else
                begin
                    ox_next   = sx_reg;
                    oy_next   = sy_reg;
                    corr_next = FAR_MARK;
                    done_next = 1'b1;
                end
            end
            ST_COR_END:
            begin
                // round, scale back and saturate
                corr_next = (cor_sum[MUL_PW-1:14] > (MUL_PW-14)'(FAR_MARK))
                            ? FAR_MARK : cor_sum[OUT_W+13:14];
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            map_cells_reg <= '0;
            map_dim_reg   <= 4'd8;
            fov_reg       <= 11'd683;
            rays_reg      <= 9'd200;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MAP_CELLS: map_cells_reg <= cfg_data;
                    CFG_MAP_DIM:   map_dim_reg   <= cfg_data[3:0];
                    CFG_FOV:       fov_reg       <= cfg_data[10:0];
                    CFG_RAYS:      rays_reg      <= cfg_data[8:0];
                    default:       map_dim_reg   <= map_dim_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= mul_a * mul_b;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        view_reg   <= view_next;
        idx_reg    <= idx_next;
        ang_reg    <= ang_next;
        sel_reg    <= sel_next;
        sn_reg     <= sn_next;
        cs_reg     <= cs_next;
        cf_reg     <= cf_next;
        z2_reg     <= z2_next;
        dir_reg    <= dir_next;
        pass_reg   <= pass_next;
        qneg_reg   <= qneg_next;
        wp_reg     <= wp_next;
        wo_reg     <= wo_next;
        pstep_reg  <= pstep_next;
        ostep_reg  <= ostep_next;
        step_reg   <= step_next;
        fh_reg     <= fh_next;
        fv_reg     <= fv_next;
        hxh_reg    <= hxh_next;
        hyh_reg    <= hyh_next;
        hxv_reg    <= hxv_next;
        hyv_reg    <= hyv_next;
        dh_reg     <= dh_next;
        dv_reg     <= dv_next;
        sq_reg     <= sq_next;
        dsel_reg   <= dsel_next;
        corr_reg   <= corr_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oside_reg  <= oside_next;
        ofound_reg <= ofound_next;
    end

    assign done               = done_reg;
    assign corrected_distance = corr_reg;
    assign hit_x              = ox_reg;
    assign hit_y              = oy_reg;
    assign wall_side          = oside_reg;
    assign wall_found         = ofound_reg;

    `GRCD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `GRCD_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `GRCD_ASSERT_IMP(a_miss_far, clk, rst_n, done && !wall_found, (corrected_distance == FAR_MARK) && wall_side)
    `GRCD_ASSERT_IMP(a_far_cap, clk, rst_n, done, corrected_distance <= FAR_MARK)

endmodule

`default_nettype wire
